@@ src/bdcc_pkg.sv @@
// ----------------------------------------------------------------------------
// Button debounce / click classifier package
// Shared widths, register indexes, reset values and click codes.
// ----------------------------------------------------------------------------
package bdcc_pkg;

    localparam int COUNT_BITS_DEF = 16;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE_TICKS   = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] REG_LONG_CLICK_TICKS = CFG_ADDR_W'(1);

    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_TICKS_RST   = CFG_DATA_W'(50);
    localparam logic [CFG_DATA_W-1:0] LONG_CLICK_TICKS_RST = CFG_DATA_W'(1000);

    // stream payloads, packed to whole bytes
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    localparam int CLICK_W = 2;
    localparam logic [CLICK_W-1:0] CLICK_NONE   = CLICK_W'(0);
    localparam logic [CLICK_W-1:0] CLICK_SINGLE = CLICK_W'(1);
    localparam logic [CLICK_W-1:0] CLICK_LONG   = CLICK_W'(2);

    typedef enum logic [2:0] {
        PH_RELEASED = 3'b001,
        PH_PRESSED  = 3'b010,
        PH_LONG     = 3'b100
    } t_phase;

    typedef struct packed {
        logic                debounced_pressed;
        logic [CLICK_W-1:0]  click_code;
    } t_result;

endpackage

@@ src/button_debounce_click_classifier_top.sv @@
// ----------------------------------------------------------------------------
// Button debounce / click classifier, top level
// Results are registered. Throughput: one tick per cycle while the skid
// stage is empty; a two-entry output (register plus skid stage) lets a new
// tick in while one finished result waits downstream.
// Reset (synchronous, active low): counters, levels and the press phase
// clear, registers load 50 / 1000 ticks, output queue empties.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_top
    import bdcc_pkg::*;
#(
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    // tick input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [S_TDATA_W-1:0]  i_s_tdata,   // [0] raw_pressed, [7:1] zero
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [M_TDATA_W-1:0]  o_m_tdata    // [0] debounced_pressed,
                                               // [2:1] click_code, [7:3] zero
);

    // Compare width covers both the counters and the 16-bit registers, so a
    // register value at or above counter saturation never matches.
    localparam int CMP_BITS = (COUNT_BITS > CFG_DATA_W) ? COUNT_BITS : CFG_DATA_W;
    localparam logic [COUNT_BITS-1:0] CNT_MAX = '1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0] r_debounce_ticks;
    logic [CFG_DATA_W-1:0] r_long_click_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_debounce_ticks   <= DEBOUNCE_TICKS_RST;
            r_long_click_ticks <= LONG_CLICK_TICKS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_DEBOUNCE_TICKS:   r_debounce_ticks   <= i_cfg_wdata;
                REG_LONG_CLICK_TICKS: r_long_click_ticks <= i_cfg_wdata;
                default: ;  // writes to unknown indexes are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Tick state
    // ------------------------------------------------------------------
    logic                  r_prev_raw;
    logic [COUNT_BITS-1:0] r_stable;
    logic                  r_deb;
    t_phase                r_phase;
    logic [COUNT_BITS-1:0] r_held;

    logic                  n_prev_raw;
    logic [COUNT_BITS-1:0] n_stable;
    logic                  n_deb;
    t_phase                n_phase;
    logic [COUNT_BITS-1:0] n_held;
    logic [CLICK_W-1:0]    n_code;
    logic [COUNT_BITS-1:0] held_inc;

    logic s_xfer;
    logic m_xfer;
    logic raw;

    assign raw    = i_s_tdata[0];
    assign s_xfer = i_s_tvalid && o_s_tready;
    assign m_xfer = o_m_tvalid && i_m_tready;

    assign held_inc = (r_held == CNT_MAX) ? r_held : r_held + 1'b1;

    always_comb begin
        n_prev_raw = raw;
        // debounce: restart on a raw change, else saturating count
        if (raw != r_prev_raw) begin
            n_stable = '0;
        end else if (r_stable == CNT_MAX) begin
            n_stable = r_stable;
        end else begin
            n_stable = r_stable + 1'b1;
        end
        n_deb = (CMP_BITS'(n_stable) > CMP_BITS'(r_debounce_ticks)) ? raw : r_deb;

        // click classification on the new debounced level
        n_phase = r_phase;
        n_held  = r_held;
        n_code  = CLICK_NONE;
        case (r_phase)
            PH_RELEASED: begin
                if (n_deb) begin
                    n_phase = PH_PRESSED;
                    n_held  = '0;
                end
            end
            PH_PRESSED: begin
                n_held = held_inc;
                if (n_deb) begin
                    if (CMP_BITS'(held_inc) > CMP_BITS'(r_long_click_ticks)) begin
                        n_code  = CLICK_LONG;
                        n_phase = PH_LONG;
                    end
                end else begin
                    n_phase = PH_RELEASED;
                    // release exactly at the long delay reports nothing
                    if (CMP_BITS'(held_inc) < CMP_BITS'(r_long_click_ticks)) begin
                        n_code = CLICK_SINGLE;
                    end
                end
            end
            default: begin  // long-pressed: wait for release
                if (!n_deb) begin
                    n_phase = PH_RELEASED;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_raw <= 1'b0;
            r_stable   <= '0;
            r_deb      <= 1'b0;
            r_phase    <= PH_RELEASED;
            r_held     <= '0;
        end else if (s_xfer) begin
            r_prev_raw <= n_prev_raw;
            r_stable   <= n_stable;
            r_deb      <= n_deb;
            r_phase    <= n_phase;
            r_held     <= n_held;
        end
    end

    // ------------------------------------------------------------------
    // Output register plus skid stage
    // ------------------------------------------------------------------
    t_result r_out;
    t_result r_skid;
    t_result new_res;
    logic    r_out_valid;
    logic    r_skid_valid;

    assign new_res.debounced_pressed = n_deb;
    assign new_res.click_code        = n_code;

    // ready only depends on the skid stage, so a waiting result never blocks
    assign o_s_tready = !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (m_xfer) begin
                r_out_valid  <= r_skid_valid || s_xfer;
                r_skid_valid <= 1'b0;
            end else if (s_xfer) begin
                if (r_out_valid) begin
                    r_skid_valid <= 1'b1;
                end else begin
                    r_out_valid <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (m_xfer) begin
            r_out <= r_skid_valid ? r_skid : new_res;
        end else if (s_xfer && !r_out_valid) begin
            r_out <= new_res;
        end
        if (s_xfer && r_out_valid && !m_xfer) begin
            r_skid <= new_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = M_TDATA_W'({r_out.click_code, r_out.debounced_pressed});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage holds data while output register is empty");

    a_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_out.click_code == CLICK_NONE ||
                        r_out.click_code == CLICK_SINGLE ||
                        r_out.click_code == CLICK_LONG))
        else $error("invalid click code");

    a_single_on_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.click_code == CLICK_SINGLE) |-> !r_out.debounced_pressed)
        else $error("single click reported while still pressed");

    a_long_while_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && r_out.click_code == CLICK_LONG) |-> r_out.debounced_pressed)
        else $error("long click reported after release");

    a_long_enters_long: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && n_code == CLICK_LONG) |=> (r_phase == PH_LONG))
        else $error("long click without entering long-pressed phase");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_xfer && r_out_valid && !m_xfer) |=> r_skid_valid)
        else $error("transfer lost while output stalled");

endmodule

@@ tb/button_debounce_click_classifier_top_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Button debounce / click classifier testbench
// Streams raw button ticks into the block and checks each result against a
// local model of the debounce counter and the press phase machine. Register
// settings change between phases, only while the block is drained.
// ----------------------------------------------------------------------------
module button_debounce_click_classifier_top_test;
    import bdcc_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 300;      // long receiver hold-off
    localparam int MAX_REPORTS   = 10;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_TICKS   = 130;      // random ticks per phase

    localparam logic [COUNT_BITS_DEF-1:0] CNT_MAX   = '1;
    localparam logic [CFG_DATA_W-1:0]     TICKS_MAX = CFG_DATA_W'(65534);
    // indexes past the register file, writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0]     REG_SPARE_2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0]     REG_SPARE_3 = CFG_ADDR_W'(3);

    typedef enum logic [1:0] {
        PRESS_IDLE,
        PRESS_HELD,
        PRESS_LONG_HELD
    } t_press;

    // ------------------------------------------------------------------
    // DUT ports, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata   = '0;   // [0] raw_pressed, [7:1] zero
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  o_m_tdata;          // [0] debounced_pressed,
                                               // [2:1] click_code, [7:3] zero

    // ------------------------------------------------------------------
    // Model state and scoreboard
    // ------------------------------------------------------------------
    logic [CFG_DATA_W-1:0]     debounce_lim;
    logic [CFG_DATA_W-1:0]     long_lim;
    logic                      prev_raw;
    logic                      level;
    logic [COUNT_BITS_DEF-1:0] stable_cnt;
    logic [COUNT_BITS_DEF-1:0] held_cnt;
    t_press                    press;

    bit      pending_ticks[$];      // raw samples not yet offered
    t_result predicted_results[$];  // results owed by the block, oldest first

    bit tick_taken      = 1'b0;     // input transfer at the last rising edge
    int src_idle_pct    = 0;
    int sink_stall_pct  = 0;
    int hold_requests   = 0;        // bumped to ask the receiver for a hold-off
    int hold_served     = 0;
    int hold_left       = 0;
    int cycle_cnt       = 0;
    int errors          = 0;
    int ticks_taken     = 0;
    int results_checked = 0;
    int singles_seen    = 0;
    int longs_seen      = 0;
    int phase_cnt       = 0;

    button_debounce_click_classifier_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Model of one tick
    // ------------------------------------------------------------------
    function automatic logic [COUNT_BITS_DEF-1:0] bump(input logic [COUNT_BITS_DEF-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

    function automatic t_result classify_tick(input logic raw);
        t_result r;
        r.click_code = CLICK_NONE;
        // debounce: level follows raw once it has been stable long enough
        stable_cnt = (raw != prev_raw) ? '0 : bump(stable_cnt);
        if (stable_cnt > debounce_lim)
            level = raw;
        prev_raw = raw;

        case (press)
            PRESS_IDLE: begin
                if (level) begin
                    press    = PRESS_HELD;
                    held_cnt = '0;
                end
            end
            PRESS_HELD: begin
                held_cnt = bump(held_cnt);
                if (level) begin
                    if (held_cnt > long_lim) begin
                        r.click_code = CLICK_LONG;
                        press        = PRESS_LONG_HELD;
                    end
                end else begin
                    press = PRESS_IDLE;
                    // a release exactly at the long delay reports nothing
                    if (held_cnt < long_lim)
                        r.click_code = CLICK_SINGLE;
                end
            end
            default: begin
                if (!level)
                    press = PRESS_IDLE;
            end
        endcase
        r.debounced_pressed = level;
        return r;
    endfunction

    function automatic bit chance(input int pct);
        return $urandom_range(99, 0) < pct;
    endfunction

    function automatic void flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("%s", msg);
    endfunction

    // ------------------------------------------------------------------
    // Sender: offers queued ticks, idles at random, holds data until taken
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_s_tvalid || tick_taken) begin
            if (i_rst_n && pending_ticks.size() != 0 && !chance(src_idle_pct)) begin
                i_s_tvalid <= 1'b1;
                i_s_tdata  <= S_TDATA_W'(pending_ticks.pop_front());
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off on request so the
    // output stage fills and the block has to drop o_s_tready
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_served != hold_requests) begin
            hold_left   = HOLD_CYCLES;
            hold_served = hold_requests;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= !chance(sink_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: predict on every input transfer, check every output transfer
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_result             want;
        logic                got_level;
        logic [CLICK_W-1:0]  got_click;

        tick_taken = i_rst_n && i_s_tvalid && o_s_tready;
        if (tick_taken) begin
            predicted_results.push_back(classify_tick(i_s_tdata[0]));
            ticks_taken++;
        end

        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got_level = o_m_tdata[0];
            got_click = o_m_tdata[2:1];
            if (predicted_results.size() == 0) begin
                flag_error($sformatf("unexpected result: level %0b click %0d",
                                     got_level, got_click));
            end else begin
                want = predicted_results.pop_front();
                if (got_level !== want.debounced_pressed ||
                    got_click !== want.click_code)
                    flag_error($sformatf(
                        "result %0d mismatch: expected level %0b click %0d, got level %0b click %0d",
                        results_checked, want.debounced_pressed, want.click_code,
                        got_level, got_click));
                if (got_click == CLICK_SINGLE)
                    singles_seen++;
                if (got_click == CLICK_LONG)
                    longs_seen++;
            end
            results_checked++;
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results still owed",
                     cycle_cnt, predicted_results.size());
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic reset_model;
        debounce_lim = DEBOUNCE_TICKS_RST;
        long_lim     = LONG_CLICK_TICKS_RST;
        prev_raw     = 1'b0;
        level        = 1'b0;
        stable_cnt   = '0;
        held_cnt     = '0;
        press        = PRESS_IDLE;
    endtask

    // only called with the block drained, so the model can update at once
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        case (addr)
            REG_DEBOUNCE_TICKS:   debounce_lim = data;
            REG_LONG_CLICK_TICKS: long_lim     = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // every tick yields a result, so an empty scoreboard means idle
    task automatic wait_drained;
        do
            @(posedge i_clk);
        while (pending_ticks.size() != 0 || i_s_tvalid || predicted_results.size() != 0);
    endtask

    task automatic start_phase(input int src_pct, input int sink_pct);
        @(posedge i_clk);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        phase_cnt++;
    endtask

    task automatic push_run(input bit raw, input int n);
        repeat (n) pending_ticks.push_back(raw);
    endtask

    // one press with bounce on both edges; hold length aimed at a single
    // click, the exact long delay, or a long click
    task automatic push_press;
        int d;
        int l;
        int n_on;
        d = int'(debounce_lim);
        l = int'(long_lim);
        repeat ($urandom_range(3, 0)) pending_ticks.push_back(1'($urandom_range(1, 0)));
        case ($urandom_range(2, 0))
            0:       n_on = d + 2 + $urandom_range(l, 0);
            1:       n_on = l - 1 + $urandom_range(2, 0);
            default: n_on = d + l + 3 + $urandom_range(8, 0);
        endcase
        if (n_on < d + 2)
            n_on = d + 2;
        push_run(1'b1, n_on);
        repeat ($urandom_range(3, 0)) pending_ticks.push_back(1'($urandom_range(1, 0)));
        push_run(1'b0, d + 2 + $urandom_range(6, 0));
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: 50 tick debounce, 1000 tick long delay
        start_phase(0, 0);
        push_run(1'b1, 60);
        push_run(1'b0, 60);
        wait_drained();

        // short delays; spare indexes must not disturb anything
        write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'(0));
        write_reg(REG_LONG_CLICK_TICKS, CFG_DATA_W'(4));
        write_reg(REG_SPARE_2, '1);
        write_reg(REG_SPARE_3, '0);
        start_phase(0, 0);
        push_run(1'b1, 3);      // single click
        push_run(1'b0, 2);
        push_run(1'b1, 4);      // released right at the long delay
        push_run(1'b0, 2);
        push_run(1'b1, 6);      // long click
        push_run(1'b0, 2);
        wait_drained();

        // zero long delay: any hold becomes a long click
        write_reg(REG_LONG_CLICK_TICKS, '0);
        start_phase(0, 0);
        push_run(1'b1, 3);
        push_run(1'b0, 2);
        wait_drained();

        // both registers at the top: a short hold moves neither the level
        // nor the press phase
        write_reg(REG_DEBOUNCE_TICKS, TICKS_MAX);
        write_reg(REG_LONG_CLICK_TICKS, TICKS_MAX);
        start_phase(0, 0);
        push_run(1'b1, 20);
        wait_drained();
        write_reg(REG_DEBOUNCE_TICKS, '0);
        start_phase(0, 0);
        push_run(1'b0, 3);
        wait_drained();

        // random phases: mostly well-formed presses, some raw noise
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_reg(REG_DEBOUNCE_TICKS, CFG_DATA_W'($urandom_range(4, 0)));
            write_reg(REG_LONG_CLICK_TICKS, CFG_DATA_W'($urandom_range(12, 0)));
            case (p % 4)
                0:       start_phase(0, 0);
                1:       start_phase(54, 0);
                2:       start_phase(0, 54);
                default: start_phase(16, 16);
            endcase
            if (p == 0)
                hold_requests++;    // back-pressure while the sender keeps going
            while (pending_ticks.size() < PHASE_TICKS) begin
                if ($urandom_range(9, 0) == 0)
                    repeat ($urandom_range(12, 1))
                        pending_ticks.push_back(1'($urandom_range(1, 0)));
                else
                    push_press();
            end
            wait_drained();
        end

        // keep running to catch any stray output
        repeat (4) @(posedge i_clk);
        errors += predicted_results.size();

        $display("Ran %0d ticks in %0d phases, idle and stall patterns on both sides",
                 ticks_taken, phase_cnt);
        $display("plus a long receiver hold-off; %0d single and %0d long clicks seen.",
                 singles_seen, longs_seen);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
